// ===== design/mtst_pkg.sv =====
package mtst_pkg;

    localparam int MAX_STRINGS = 128;
    localparam int MAX_LEN     = 4096;
    localparam int MAX_QUERY   = 4096;
    localparam int UNDO_DEPTH  = 65536;

    localparam int IDX_W   = $clog2(MAX_STRINGS);
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int PTR_W   = POS_W + 1;
    localparam int TADDR_W = IDX_W + POS_W;
    localparam int LOG_AW  = $clog2(UNDO_DEPTH);
    localparam int UTOP_W  = LOG_AW + 1;
    localparam int MARK_AW = $clog2(MAX_QUERY);
    localparam int MTOP_W  = MARK_AW + 1;
    localparam int LET_W   = 5;
    localparam int CNT_W   = 8;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_APPEND = 2'd2,
        OP_BKSP   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // write into the match state memory
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [PTR_W-1:0] ptr;
        logic             alive;
    } match_wr_t;

endpackage

// ===== design/mtst_text_mem.sv =====
module mtst_text_mem
    import mtst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [TADDR_W-1:0] wr_addr,
    input  logic [LET_W-1:0]   wr_letter,
    input  logic               len_wr_en,
    input  logic [IDX_W-1:0]   len_wr_idx,
    input  logic [PTR_W-1:0]   len_wr_data,
    input  logic               rd_en,
    input  logic [TADDR_W-1:0] rd_addr,
    output logic [LET_W-1:0]   rd_letter,
    input  logic               len_rd_en,
    input  logic [IDX_W-1:0]   len_rd_idx,
    output logic [PTR_W-1:0]   len_rd_data
);

    logic [LET_W-1:0] text_mem [MAX_LEN*MAX_STRINGS];
    logic [PTR_W-1:0] len_mem  [MAX_STRINGS];
    logic [MAX_STRINGS-1:0] len_valid_reg;
    logic [PTR_W-1:0] len_q_reg;
    logic             len_q_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            text_mem[wr_addr] <= wr_letter;
        end
        if (rd_en) begin
            rd_letter <= text_mem[rd_addr];
        end
        if (len_wr_en) begin
            len_mem[len_wr_idx] <= len_wr_data;
        end
        if (len_rd_en) begin
            len_q_reg <= len_mem[len_rd_idx];
        end
    end

    // unwritten lengths read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg   <= '0;
            len_q_valid_reg <= 1'b0;
        end else begin
            if (len_wr_en) begin
                len_valid_reg[len_wr_idx] <= 1'b1;
            end
            if (len_rd_en) begin
                len_q_valid_reg <= len_valid_reg[len_rd_idx];
            end
        end
    end

    assign len_rd_data = len_q_valid_reg ? len_q_reg : '0;

endmodule

// ===== design/mtst_match_mem.sv =====
module mtst_match_mem
    import mtst_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CNT_W-1:0] start_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    input  match_wr_t        wr,
    output logic [PTR_W-1:0] rd_ptr,
    output logic             rd_alive
);

    logic [PTR_W:0] state_mem [MAX_STRINGS];
    logic [PTR_W:0] q_reg;
    logic [MAX_STRINGS-1:0] valid_reg;
    logic [CNT_W-1:0] start_n_reg;
    logic q_valid_reg;
    logic q_in_set_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            state_mem[wr.idx] <= {wr.ptr, wr.alive};
        end
        if (rd_en) begin
            q_reg <= state_mem[rd_idx];
        end
    end

    // a start clears every entry at once: an invalid entry is alive
    // with pointer zero when its text takes part, else dead
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            start_n_reg  <= '0;
            q_valid_reg  <= 1'b0;
            q_in_set_reg <= 1'b0;
        end else begin
            if (start) begin
                valid_reg   <= '0;
                start_n_reg <= start_n;
            end else if (wr.en) begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (rd_en) begin
                q_valid_reg  <= valid_reg[rd_idx];
                q_in_set_reg <= {1'b0, rd_idx} < start_n_reg;
            end
        end
    end

    assign rd_ptr   = q_valid_reg ? q_reg[PTR_W:1] : '0;
    assign rd_alive = q_valid_reg ? q_reg[0] : q_in_set_reg;

endmodule

// ===== design/multi_text_subsequence_tracker.sv =====
// Multi-text subsequence tracker. Holds 128 texts of up to 4096 letters, loaded
// one letter per item, and answers after every item with the number of texts
// that contain the current query as a subsequence. Items: load letter, start
// query (texts below num_strings become live), append letter, backspace. Each
// item gives exactly one result item. An append visits all 128 texts and, in
// each live text, compares letters from its match pointer on until a hit or the
// end of the text, so its cost is set by the single read port of the text
// memory. A backspace replays the undo log entries back to its mark. One item
// is in work at a time, while the previous result may still wait in the output
// register. num_strings is read only by start. No clearing pass is needed after
// reset.
module multi_text_subsequence_tracker
    import mtst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // slave: [1:0] operation, [8:2] string_index, [20:9] position, [25:21] letter
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,   // last_of_string
    // master: [7:0] match_count, [9:8] status
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // num_strings register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_AP_RD   = 10'b0000000010,
        S_AP_CHK  = 10'b0000000100,
        S_AP_SCAN = 10'b0000001000,
        S_AP_CMP  = 10'b0000010000,
        S_BS_MARK = 10'b0000100000,
        S_BS_TEST = 10'b0001000000,
        S_BS_LOG  = 10'b0010000000,
        S_BS_FIX  = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } state_t;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(MAX_STRINGS - 1);
    localparam logic [UTOP_W:0]   UNDO_LIMIT = (UTOP_W+1)'(UNDO_DEPTH);
    localparam logic [MTOP_W-1:0] MARK_LIMIT = MTOP_W'(MAX_QUERY);
    localparam logic [CNT_W-1:0]  NS_LIMIT   = CNT_W'(MAX_STRINGS);

    state_t state_reg, state_next;

    // input fields
    op_t              in_op;
    logic [IDX_W-1:0] in_idx;
    logic [POS_W-1:0] in_pos;
    logic [LET_W-1:0] in_letter;
    logic             accept;

    assign in_op     = op_t'(s_axis_tdata[1:0]);
    assign in_idx    = s_axis_tdata[8:2];
    assign in_pos    = s_axis_tdata[20:9];
    assign in_letter = s_axis_tdata[25:21];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;

    // control registers
    logic [CNT_W-1:0]  num_strings_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [UTOP_W-1:0] undo_top_reg;
    logic [MTOP_W-1:0] mark_top_reg;
    logic [IDX_W-1:0]  text_reg;
    logic [PTR_W-1:0]  scan_reg;
    logic [LET_W-1:0]  letter_reg;
    logic [UTOP_W-1:0] target_reg;
    status_t           status_reg;
    logic              m_valid_reg;
    logic [15:0]       m_data_reg;

    // undo log and mark stack
    logic [IDX_W+PTR_W-1:0] log_mem [UNDO_DEPTH];
    logic [UTOP_W-1:0]      mark_mem [MAX_QUERY];
    logic [IDX_W+PTR_W-1:0] log_q_reg;
    logic [UTOP_W-1:0]      mark_q_reg;

    logic log_wr, log_rd, mark_wr, mark_rd;
    logic [IDX_W+PTR_W-1:0] log_wdata;

    // memory interfaces
    logic             st_start;
    logic [CNT_W-1:0] st_start_n;
    logic             st_rd_en;
    logic [IDX_W-1:0] st_rd_idx;
    match_wr_t        st_wr;
    logic [PTR_W-1:0] st_ptr;
    logic             st_alive;
    logic             txt_rd_en;
    logic [LET_W-1:0] txt_letter;
    logic [PTR_W-1:0] txt_len;
    logic             is_load;

    logic [IDX_W-1:0] log_t;
    logic [PTR_W-1:0] log_p;
    logic [UTOP_W:0]  undo_need;
    logic             full;

    assign log_t = log_q_reg[IDX_W+PTR_W-1:PTR_W];
    assign log_p = log_q_reg[PTR_W-1:0];
    assign undo_need = {1'b0, undo_top_reg} + (UTOP_W+1)'(live_reg);
    assign full = (mark_top_reg == MARK_LIMIT) || (undo_need > UNDO_LIMIT);
    assign is_load = accept && (in_op == OP_LOAD);

    assign st_start   = accept && (in_op == OP_START);
    assign st_start_n = (num_strings_reg > NS_LIMIT) ? NS_LIMIT : num_strings_reg;
    assign st_rd_en   = (state_reg == S_AP_RD) || (state_reg == S_BS_LOG);
    assign st_rd_idx  = (state_reg == S_BS_LOG) ? log_t : text_reg;
    assign txt_rd_en  = (state_reg == S_AP_SCAN) && (scan_reg < txt_len);

    assign log_wr    = (state_reg == S_AP_CHK) && st_alive;
    assign log_wdata = {text_reg, st_ptr};
    assign log_rd    = (state_reg == S_BS_TEST) && (undo_top_reg > target_reg);
    assign mark_wr   = accept && (in_op == OP_APPEND) && !full;
    assign mark_rd   = accept && (in_op == OP_BKSP) && (mark_top_reg != '0);

    always_ff @(posedge aclk) begin
        if (log_wr) begin
            log_mem[undo_top_reg[LOG_AW-1:0]] <= log_wdata;
        end
        if (log_rd) begin
            log_q_reg <= log_mem[LOG_AW'(undo_top_reg - 1'b1)];
        end
        if (mark_wr) begin
            mark_mem[mark_top_reg[MARK_AW-1:0]] <= undo_top_reg;
        end
        if (mark_rd) begin
            mark_q_reg <= mark_mem[MARK_AW'(mark_top_reg - 1'b1)];
        end
    end

    // writes into the match state
    always_comb begin
        st_wr = '0;
        unique case (state_reg)
            S_AP_SCAN: begin
                if (!(scan_reg < txt_len)) begin
                    st_wr = '{en: 1'b1, idx: text_reg, ptr: scan_reg, alive: 1'b0};
                end
            end
            S_AP_CMP: begin
                if (txt_letter == letter_reg) begin
                    st_wr = '{en: 1'b1, idx: text_reg, ptr: scan_reg + 1'b1,
                              alive: 1'b1};
                end
            end
            S_BS_FIX: begin
                st_wr = '{en: 1'b1, idx: log_t, ptr: log_p, alive: 1'b1};
            end
            default: begin
                st_wr = '0;
            end
        endcase
    end

    mtst_text_mem u_text (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (is_load),
        .wr_addr     ({in_idx, in_pos}),
        .wr_letter   (in_letter),
        .len_wr_en   (is_load && s_axis_tlast),
        .len_wr_idx  (in_idx),
        .len_wr_data ({1'b0, in_pos} + 1'b1),
        .rd_en       (txt_rd_en),
        .rd_addr     ({text_reg, scan_reg[POS_W-1:0]}),
        .rd_letter   (txt_letter),
        .len_rd_en   (state_reg == S_AP_RD),
        .len_rd_idx  (text_reg),
        .len_rd_data (txt_len)
    );

    mtst_match_mem u_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (st_start),
        .start_n  (st_start_n),
        .rd_en    (st_rd_en),
        .rd_idx   (st_rd_idx),
        .wr       (st_wr),
        .rd_ptr   (st_ptr),
        .rd_alive (st_alive)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_APPEND: state_next = full ? S_DONE : S_AP_RD;
                        OP_BKSP:   state_next = (mark_top_reg == '0) ? S_DONE : S_BS_MARK;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_AP_RD: state_next = S_AP_CHK;
            S_AP_CHK: begin
                if (st_alive) begin
                    state_next = S_AP_SCAN;
                end else begin
                    state_next = (text_reg == LAST_IDX) ? S_DONE : S_AP_RD;
                end
            end
            S_AP_SCAN: begin
                if (scan_reg < txt_len) begin
                    state_next = S_AP_CMP;
                end else begin
                    state_next = (text_reg == LAST_IDX) ? S_DONE : S_AP_RD;
                end
            end
            S_AP_CMP: begin
                if (txt_letter == letter_reg) begin
                    state_next = (text_reg == LAST_IDX) ? S_DONE : S_AP_RD;
                end else begin
                    state_next = S_AP_SCAN;
                end
            end
            S_BS_MARK: state_next = S_BS_TEST;
            S_BS_TEST: state_next = log_rd ? S_BS_LOG : S_DONE;
            S_BS_LOG:  state_next = S_BS_FIX;
            S_BS_FIX:  state_next = S_BS_TEST;
            S_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            num_strings_reg <= CNT_W'(1);
            live_reg        <= '0;
            undo_top_reg    <= '0;
            mark_top_reg    <= '0;
            text_reg        <= '0;
            status_reg      <= ST_OK;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                num_strings_reg <= cfg_data;
            end
            // result register: load when the item is done, else drain
            if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        status_reg <= ST_OK;
                        text_reg   <= '0;
                        unique case (in_op)
                            OP_START: begin
                                live_reg     <= st_start_n;
                                undo_top_reg <= '0;
                                mark_top_reg <= '0;
                            end
                            OP_APPEND: begin
                                if (full) begin
                                    status_reg <= ST_FULL;
                                end else begin
                                    mark_top_reg <= mark_top_reg + 1'b1;
                                end
                            end
                            OP_BKSP: begin
                                if (mark_top_reg == '0) begin
                                    status_reg <= ST_EMPTY;
                                end else begin
                                    mark_top_reg <= mark_top_reg - 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_AP_CHK: begin
                    if (st_alive) begin
                        undo_top_reg <= undo_top_reg + 1'b1;
                    end else begin
                        text_reg <= text_reg + 1'b1;
                    end
                end
                S_AP_SCAN: begin
                    if (!(scan_reg < txt_len)) begin
                        // no further hit: the text drops out
                        live_reg <= live_reg - 1'b1;
                        text_reg <= text_reg + 1'b1;
                    end
                end
                S_AP_CMP: begin
                    if (txt_letter == letter_reg) begin
                        text_reg <= text_reg + 1'b1;
                    end
                end
                S_BS_TEST: begin
                    if (log_rd) begin
                        undo_top_reg <= undo_top_reg - 1'b1;
                    end
                end
                S_BS_FIX: begin
                    if (!st_alive) begin
                        live_reg <= live_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            letter_reg <= in_letter;
        end
        if (state_reg == S_AP_CHK) begin
            scan_reg <= st_ptr;
        end else if (state_reg == S_AP_CMP) begin
            scan_reg <= scan_reg + 1'b1;
        end
        if (state_reg == S_BS_MARK) begin
            target_reg <= mark_q_reg;
        end
        if (state_reg == S_DONE && (!m_valid_reg || m_axis_tready)) begin
            m_data_reg <= {6'd0, status_reg, live_reg};
        end
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== tb/multi_text_subsequence_tracker_tb.sv =====
`timescale 1ns / 100ps

module multi_text_subsequence_tracker_tb;
    import mtst_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [1:0] operation, [8:2] string_index,
                                      // [20:9] position, [25:21] letter
    logic        s_axis_tlast = 1'b0; // last_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // [7:0] match_count, [9:8] status
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    multi_text_subsequence_tracker dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // expected result item
    typedef struct {
        logic [7:0] count;
        status_t    st;
    } tally_t;

    // predictor state; short texts only, so a small letter store suffices
    localparam int TXT_MAX = 32;
    logic [4:0]  text_mem [MAX_STRINGS][TXT_MAX];
    int unsigned text_len [MAX_STRINGS];
    int unsigned ptr_q    [MAX_STRINGS];
    bit          alive_q  [MAX_STRINGS];
    int unsigned log_text[$];
    int unsigned log_ptr[$];
    int unsigned marks[$];
    int unsigned live_n;
    int unsigned n_strings;

    tally_t tally_q[$];
    int     errors = 0;
    int     send_idle = 0;   // percent of cycles the sender idles
    int     recv_idle = 0;   // percent of cycles the receiver stalls
    longint cycles = 0;

    // work out the result of one item and update the predictor state
    function automatic tally_t predict_tally(op_t op, int unsigned idx, int unsigned pos,
                                             logic [4:0] ltr, bit last);
        tally_t      r;
        int unsigned p;
        int unsigned tgt;
        bit          hit;
        r.st = ST_OK;
        case (op)
            OP_LOAD: begin
                if (pos < TXT_MAX) text_mem[idx][pos] = ltr;
                if (last) text_len[idx] = pos + 1;
            end
            OP_START: begin
                live_n = (n_strings > MAX_STRINGS) ? MAX_STRINGS : n_strings;
                for (int i = 0; i < MAX_STRINGS; i++) begin
                    alive_q[i] = (i < live_n);
                    ptr_q[i] = 0;
                end
                log_text.delete(); log_ptr.delete(); marks.delete();
            end
            OP_APPEND: begin
                if (marks.size() >= MAX_QUERY || log_text.size() + live_n > UNDO_DEPTH)
                    r.st = ST_FULL;
                else begin
                    marks.insert(marks.size(), log_text.size());
                    for (int i = 0; i < MAX_STRINGS; i++) begin
                        if (!alive_q[i]) continue;
                        log_text.insert(log_text.size(), i);
                        log_ptr.insert(log_ptr.size(), ptr_q[i]);
                        hit = 0;
                        for (p = ptr_q[i]; p < text_len[i]; p++)
                            if (text_mem[i][p] == ltr) begin
                                hit = 1;
                                break;
                            end
                        if (hit) ptr_q[i] = p + 1;
                        else begin
                            alive_q[i] = 0;
                            live_n--;
                        end
                    end
                end
            end
            default: begin
                if (marks.size() == 0) r.st = ST_EMPTY;
                else begin
                    tgt = marks.pop_back();
                    while (log_text.size() > tgt) begin
                        p = log_text.pop_back();
                        if (!alive_q[p]) begin
                            alive_q[p] = 1;
                            live_n++;
                        end
                        ptr_q[p] = log_ptr.pop_back();
                    end
                end
            end
        endcase
        r.count = live_n[7:0];
        return r;
    endfunction

    // send one item and queue its expected result
    task automatic send_item(op_t op, int unsigned idx = 0, int unsigned pos = 0,
                             logic [4:0] ltr = 0, bit last = 0);
        while ($urandom_range(99) < send_idle) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, ltr, pos[11:0], idx[6:0], op};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        tally_q.push_back(predict_tally(op, idx, pos, ltr, last));
        s_axis_tvalid <= 1'b0;
        // the block is busy for at least this cycle after an item
        @(posedge aclk);
    endtask

    task automatic write_num_strings(logic [7:0] v);
        wait (tally_q.size() == 0);
        repeat (20) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_strings = v;
    endtask

    // load a whole text of the given length with random letters
    task automatic load_text(int unsigned idx, int unsigned len);
        for (int unsigned p = 0; p < len; p++)
            send_item(OP_LOAD, idx, p, 5'($urandom_range(3)), p == len - 1);
    endtask

    // receiver stall and result checking
    always @(posedge aclk) begin
        tally_t e;
        if (aresetn) begin
            cycles <= cycles + 1;
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
            if (m_axis_tvalid && m_axis_tready) begin
                if (tally_q.size() == 0) begin
                    $display("%0t: result with nothing expected: count %0d status %0d",
                             $time, m_axis_tdata[7:0], m_axis_tdata[9:8]);
                    errors++;
                end else begin
                    e = tally_q.pop_front();
                    if (m_axis_tdata[7:0] !== e.count) begin
                        $display("%0t: match_count expected %0d actual %0d",
                                 $time, e.count, m_axis_tdata[7:0]);
                        errors++;
                    end
                    if (m_axis_tdata[9:8] !== e.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.st, m_axis_tdata[9:8]);
                        errors++;
                    end
                end
            end
        end
    end

    // extremes of the fields, loads out of the contract ignored, error statuses
    task automatic test_directed();
        send_item(OP_BKSP);                       // backspace on empty query
        send_item(OP_APPEND, 0, 0, 5'd0);         // append before any start
        send_item(OP_BKSP);
        send_item(OP_LOAD, 127, 4095, 5'd31, 1'b0); // far corner, never scanned
        send_item(OP_LOAD, 0, 0, 5'd0, 1'b1);
        send_item(OP_START);
        send_item(OP_APPEND, 0, 0, 5'd25);        // text "a" dies on z
        send_item(OP_BKSP);
        send_item(OP_APPEND, 0, 0, 5'd0);
        send_item(OP_APPEND, 0, 0, 5'd0);
        send_item(OP_APPEND, 0, 0, 5'd31);        // raw code above 25
        send_item(OP_BKSP);
        send_item(OP_BKSP);
        send_item(OP_BKSP);
        send_item(OP_BKSP);
    endtask

    // several texts with random content, then mostly well-formed queries
    task automatic test_queries(int n_texts, int n_ops);
        int k;
        for (int t = 0; t < n_texts; t++) load_text(t, $urandom_range(1, 8));
        send_item(OP_START);
        for (int i = 0; i < n_ops; i++) begin
            k = $urandom_range(9);
            if (k < 6)      send_item(OP_APPEND, 0, 0, 5'($urandom_range(3)));
            else if (k < 9) send_item(OP_BKSP);
            else            send_item(OP_START);
        end
    endtask

    // every text active, plus a load at a random position that never ends a text
    task automatic test_all_texts();
        for (int t = 0; t < MAX_STRINGS; t += 9)
            send_item(OP_LOAD, t, 0, 5'($urandom_range(31)), 1'b1);
        send_item(OP_LOAD, $urandom_range(127), $urandom_range(4095),
                  5'($urandom_range(31)), 1'b0);
        send_item(OP_START);
        send_item(OP_APPEND, 0, 0, 5'd0);
        send_item(OP_APPEND, 0, 0, 5'd0);
        send_item(OP_BKSP);
        send_item(OP_BKSP);
    endtask

    initial begin
        for (int i = 0; i < MAX_STRINGS; i++) begin
            text_len[i] = 0; ptr_q[i] = 0; alive_q[i] = 0;
            for (int j = 0; j < TXT_MAX; j++) text_mem[i][j] = '0;
        end
        live_n = 0;
        n_strings = 1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 10; recv_idle = 82;
        test_directed();
        write_num_strings(8'd5);
        test_queries(5, 25);

        send_idle = 82; recv_idle = 10;
        write_num_strings(8'd0);                  // no texts at all
        send_item(OP_START);
        send_item(OP_APPEND, 0, 0, 5'd1);
        send_item(OP_BKSP);
        write_num_strings(8'd255);                // saturates
        test_all_texts();

        send_idle = 0; recv_idle = 0;
        write_num_strings(8'd128);
        test_all_texts();
        write_num_strings(8'd3);
        test_queries(3, 25);

        wait (tally_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > 2000000) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
